FILE: rtl/core/sqsw_pkg.sv
// shared types, constants and helpers for the square sweep channel control
`timescale 1ns / 1ps
package sqsw_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [11:0] FREQ_MAX   = 12'd2047;
  localparam logic [11:0] FREQ_SPAN  = 12'd2048;
  localparam logic [6:0]  LEN_FULL   = 7'd64;
  localparam logic [6:0]  LEN_SHORT  = 7'd63;
  localparam logic [3:0]  VOL_MAX    = 4'd15;
  localparam logic [3:0]  PERIOD_MAX = 4'd8;

  typedef enum logic [2:0] {
    FUNC_TRIGGER  = 3'd0,
    FUNC_LENGTH   = 3'd1,
    FUNC_ENVELOPE = 3'd2,
    FUNC_SWEEP    = 3'd3,
    FUNC_SAMPLE   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    REG_SWEEP_PACE      = 3'd0,
    REG_SWEEP_SHIFT     = 3'd1,
    REG_SWEEP_NEGATE    = 3'd2,
    REG_DUTY_SELECT     = 3'd3,
    REG_START_VOLUME    = 3'd4,
    REG_ENVELOPE_UP     = 3'd5,
    REG_ENVELOPE_PERIOD = 3'd6,
    REG_LENGTH_EN       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] sweep_pace;
    logic [2:0] sweep_shift;
    logic       sweep_negate;
    logic [1:0] duty_select;
    logic [3:0] start_volume;
    logic       envelope_up;
    logic [2:0] envelope_period;
    logic       length_en;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] freq;
    logic        next_not_length_step;
    logic        next_is_envelope_step;
    logic [2:0]  duty_position;
  } event_t;

  typedef struct packed {
    logic signed [4:0] sample;
    logic              channel_on;
    logic [10:0]       freq;
    logic [13:0]       timer_period;
    logic [3:0]        volume;
  } result_t;

  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0: pat = 8'h01;
      2'd1: pat = 8'h81;
      2'd2: pat = 8'h87;
      2'd3: pat = 8'h7E;
      default: pat = 8'h01;
    endcase
    return pat;
  endfunction

  function automatic logic [3:0] period_of(input logic [2:0] p);
    return (p == 3'd0) ? PERIOD_MAX : {1'b0, p};
  endfunction

  // 12-bit result, bit 11 set means above the frequency range
  function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
                                             input logic [2:0]  shift,
                                             input logic        negate);
    logic [10:0] step;
    step = shadow >> shift;
    return negate ? ({1'b0, shadow} - {1'b0, step}) : ({1'b0, shadow} + {1'b0, step});
  endfunction

endpackage

FILE: rtl/core/sqsw_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module sqsw_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqsw_pkg::ADDR_W-1:0]   paddr,
  input  logic [sqsw_pkg::DATA_W-1:0]   pwdata,
  output logic [sqsw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output sqsw_pkg::cfg_t                cfg
);
  import sqsw_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_SWEEP_PACE:      cfg.sweep_pace      <= pwdata[2:0];
        REG_SWEEP_SHIFT:     cfg.sweep_shift     <= pwdata[2:0];
        REG_SWEEP_NEGATE:    cfg.sweep_negate    <= pwdata[0];
        REG_DUTY_SELECT:     cfg.duty_select     <= pwdata[1:0];
        REG_START_VOLUME:    cfg.start_volume    <= pwdata[3:0];
        REG_ENVELOPE_UP:     cfg.envelope_up     <= pwdata[0];
        REG_ENVELOPE_PERIOD: cfg.envelope_period <= pwdata[2:0];
        REG_LENGTH_EN:       cfg.length_en       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SWEEP_PACE:      prdata[2:0] = cfg.sweep_pace;
      REG_SWEEP_SHIFT:     prdata[2:0] = cfg.sweep_shift;
      REG_SWEEP_NEGATE:    prdata[0]   = cfg.sweep_negate;
      REG_DUTY_SELECT:     prdata[1:0] = cfg.duty_select;
      REG_START_VOLUME:    prdata[3:0] = cfg.start_volume;
      REG_ENVELOPE_UP:     prdata[0]   = cfg.envelope_up;
      REG_ENVELOPE_PERIOD: prdata[2:0] = cfg.envelope_period;
      REG_LENGTH_EN:       prdata[0]   = cfg.length_en;
      default:             prdata      = '0;
    endcase
  end

endmodule

FILE: rtl/core/sqsw_chan.sv
// channel state and the single-pass update that forms each result
`timescale 1ns / 1ps
module sqsw_chan (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  sqsw_pkg::event_t  ev,
  input  sqsw_pkg::cfg_t    cfg,
  output sqsw_pkg::result_t res
);
  import sqsw_pkg::*;

  logic        enabled, enabled_next;
  logic [6:0]  length_left, length_left_next;
  logic [3:0]  volume, volume_next;
  logic [3:0]  envelope_timer, envelope_timer_next;
  logic        envelope_stopped, envelope_stopped_next;
  logic [3:0]  sweep_cnt, sweep_cnt_next;
  logic [10:0] shadow_freq, shadow_freq_next;
  logic        sweep_active, sweep_active_next;
  logic [10:0] current_freq, current_freq_next;

  logic [11:0] calc_trig, calc_cur, calc_second, span;
  logic [7:0]  pat;
  logic        high;

  assign calc_trig   = sweep_calc(ev.freq, cfg.sweep_shift, cfg.sweep_negate);
  assign calc_cur    = sweep_calc(shadow_freq, cfg.sweep_shift, cfg.sweep_negate);
  assign calc_second = sweep_calc(calc_cur[10:0], cfg.sweep_shift, cfg.sweep_negate);

  always_comb begin
    enabled_next          = enabled;
    length_left_next      = length_left;
    volume_next           = volume;
    envelope_timer_next   = envelope_timer;
    envelope_stopped_next = envelope_stopped;
    sweep_cnt_next        = sweep_cnt;
    shadow_freq_next      = shadow_freq;
    sweep_active_next     = sweep_active;
    current_freq_next     = current_freq;
    case (ev.func)
      FUNC_TRIGGER: begin
        enabled_next = 1'b1;
        if (length_left == 7'd0) begin
          length_left_next = (cfg.length_en && ev.next_not_length_step) ?
                             LEN_SHORT : LEN_FULL;
        end
        envelope_stopped_next = 1'b0;
        envelope_timer_next   = period_of(cfg.envelope_period) +
                                {3'd0, ev.next_is_envelope_step};
        volume_next           = cfg.start_volume;
        current_freq_next     = ev.freq;
        sweep_cnt_next        = period_of(cfg.sweep_pace);
        shadow_freq_next      = ev.freq;
        sweep_active_next     = (cfg.sweep_pace != 3'd0) || (cfg.sweep_shift != 3'd0);
        if (cfg.sweep_shift != 3'd0 && calc_trig > FREQ_MAX) begin
          enabled_next = 1'b0;
        end
        // dac off
        if (cfg.start_volume == 4'd0 && !cfg.envelope_up) begin
          enabled_next = 1'b0;
        end
      end
      FUNC_LENGTH: begin
        if (cfg.length_en && length_left != 7'd0) begin
          length_left_next = length_left - 7'd1;
          if (length_left == 7'd1) begin
            enabled_next = 1'b0;
          end
        end
      end
      FUNC_ENVELOPE: begin
        if (!envelope_stopped) begin
          if (envelope_timer > 4'd1) begin
            envelope_timer_next = envelope_timer - 4'd1;
          end else begin
            envelope_timer_next = period_of(cfg.envelope_period);
            if (cfg.envelope_period != 3'd0) begin
              if (cfg.envelope_up) begin
                if (volume < VOL_MAX) volume_next = volume + 4'd1;
                else envelope_stopped_next = 1'b1;
              end else begin
                if (volume != 4'd0) volume_next = volume - 4'd1;
                else envelope_stopped_next = 1'b1;
              end
            end
          end
        end
      end
      FUNC_SWEEP: begin
        if (sweep_active && enabled) begin
          if (sweep_cnt > 4'd1) begin
            sweep_cnt_next = sweep_cnt - 4'd1;
          end else begin
            sweep_cnt_next = period_of(cfg.sweep_pace);
            if (cfg.sweep_pace != 3'd0) begin
              if (calc_cur > FREQ_MAX) begin
                enabled_next = 1'b0;
              end else if (cfg.sweep_shift != 3'd0) begin
                shadow_freq_next  = calc_cur[10:0];
                current_freq_next = calc_cur[10:0];
                // second overflow check on the new shadow value
                if (calc_second > FREQ_MAX) begin
                  enabled_next = 1'b0;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign pat  = duty_pattern(cfg.duty_select);
  assign high = pat[3'd7 - ev.duty_position];
  assign span = FREQ_SPAN - {1'b0, current_freq_next};

  always_comb begin
    res.sample       = high ? $signed({1'b0, volume_next}) : $signed(5'd0 - {1'b0, volume_next});
    res.channel_on   = enabled_next;
    res.freq         = current_freq_next;
    res.timer_period = {span, 2'b00};
    res.volume       = volume_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b0;
      length_left      <= '0;
      volume           <= '0;
      envelope_timer   <= '0;
      envelope_stopped <= 1'b0;
      sweep_cnt        <= '0;
      shadow_freq      <= '0;
      sweep_active     <= 1'b0;
      current_freq     <= '0;
    end else if (upd) begin
      enabled          <= enabled_next;
      length_left      <= length_left_next;
      volume           <= volume_next;
      envelope_timer   <= envelope_timer_next;
      envelope_stopped <= envelope_stopped_next;
      sweep_cnt        <= sweep_cnt_next;
      shadow_freq      <= shadow_freq_next;
      sweep_active     <= sweep_active_next;
      current_freq     <= current_freq_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_dac_off: assert property (@(posedge clk) disable iff (rst)
    upd && ev.func == FUNC_TRIGGER && cfg.start_volume == 4'd0 && !cfg.envelope_up
    |=> !enabled)
    else $error("trigger with dac off left channel enabled");

  a_length_end: assert property (@(posedge clk) disable iff (rst)
    upd && ev.func == FUNC_LENGTH && cfg.length_en && length_left == 7'd1
    |=> !enabled && length_left == 7'd0)
    else $error("length expiry did not stop channel");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    upd && ev.func == FUNC_SWEEP && !(sweep_active && enabled)
    |=> $stable(shadow_freq) && $stable(current_freq) && $stable(sweep_cnt))
    else $error("sweep tick changed state while sweep off");
`endif

endmodule

FILE: rtl/core/square_sweep_channel_control.sv
// top level: event register, channel update, result register and config port
`timescale 1ns / 1ps
// Control part of a square-wave sound channel with frequency sweep. Each event
// item (trigger, length tick, envelope tick, sweep tick or sample request) gives
// exactly one result item: the signed duty sample, the enable flag, the current
// frequency, the frequency timer period and the volume, all after the event's
// update. An accepted item is held in the event register; the single update pass
// moves it into the result register once that one is empty or being taken, and
// the result is offered from there. One item can be taken every cycle while
// results are drained; a result that is not taken holds the event register, and
// event_ready drops once that register is full too, so at most two items are in
// flight. Configuration registers sit at byte addresses 4*i and must be written
// only while no item is in flight; this binds the user, the block does not enforce it.
module square_sweep_channel_control (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqsw_pkg::ADDR_W-1:0]   paddr,
  input  logic [sqsw_pkg::DATA_W-1:0]   pwdata,
  output logic [sqsw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          event_valid,
  output logic                          event_ready,
  input  logic [2:0]                    func,
  input  logic [10:0]                   freq_in,
  input  logic                          next_not_length_step,
  input  logic                          next_is_envelope_step,
  input  logic [2:0]                    duty_position,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [4:0]             sample_out,
  output logic                          channel_on,
  output logic [10:0]                   freq_out,
  output logic [13:0]                   timer_period,
  output logic [3:0]                    volume_out
);
  import sqsw_pkg::*;

  cfg_t    cfg;
  event_t  ev;
  result_t res;
  result_t res_q;
  logic    ev_valid;
  logic    move;

  sqsw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign move        = ev_valid && (!result_valid || result_ready);
  assign event_ready = !ev_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (event_ready) begin
      ev_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && event_ready) begin
      ev.func                  <= func;
      ev.freq                  <= freq_in;
      ev.next_not_length_step  <= next_not_length_step;
      ev.next_is_envelope_step <= next_is_envelope_step;
      ev.duty_position         <= duty_position;
    end
  end

  sqsw_chan u_chan (
    .clk (clk),
    .rst (rst),
    .upd (move),
    .ev  (ev),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_q <= res;
    end
  end

  assign sample_out   = res_q.sample;
  assign channel_on   = res_q.channel_on;
  assign freq_out     = res_q.freq;
  assign timer_period = res_q.timer_period;
  assign volume_out   = res_q.volume;

endmodule
